>>> rtl/gmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmp_pkg
// Shared types, register indexes and saturating arithmetic for the grid
// minimum-path cost and count block.
// ----------------------------------------------------------------------------
package gmp_pkg;

    typedef logic signed [15:0] cell_t;
    typedef logic signed [23:0] cost_t;
    typedef logic        [63:0] count_t;

    typedef struct packed {
        cost_t  cost;
        count_t count;
    } entry_t;

    typedef struct packed {
        logic first_diag;
        logic first_pos;
        logic eod;
        logic final_diag;
        logic is_last;
        logic perc;
    } flags_t;

    localparam logic [7:0] REG_GRID_SIZE = 8'd0;
    localparam logic [7:0] REG_PERC_MODE = 8'd1;

    localparam logic [8:0] GRID_SIZE_RESET = 9'd16;

    localparam cost_t  COST_MAX  = 24'sh7FFFFF;
    localparam cost_t  COST_MIN  = 24'sh800000;
    localparam count_t COUNT_MAX = {64{1'b1}};
    localparam count_t COUNT_ONE = 64'd1;

    function automatic cost_t sat_add_cost(input cost_t a, input cell_t b);
        logic [24:0] s;
        s = {a[23], a} + {{9{b[15]}}, b};
        if (s[24] != s[23]) begin
            return s[24] ? COST_MIN : COST_MAX;
        end
        return s[23:0];
    endfunction

    function automatic count_t sat_add_count(input count_t a, input count_t b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? COUNT_MAX : s[63:0];
    endfunction

endpackage

>>> rtl/gmp_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmp_store
// Previous-diagonal memory: one write port and one registered read port,
// read before write when both hit the same address.
// ----------------------------------------------------------------------------
module gmp_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  gmp_pkg::entry_t   wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output gmp_pkg::entry_t   rd_data
);
    import gmp_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/gmp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmp_ctrl
// Configuration registers and the diagonal / position sequencer.
// ----------------------------------------------------------------------------
module gmp_ctrl #(
    parameter int MAX_SIZE = 256,
    parameter int AW       = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [7:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              advance,
    output logic [AW-1:0]     pos,
    output gmp_pkg::flags_t   flags
);
    import gmp_pkg::*;

    localparam int NW = AW + 1;
    localparam int EW = (NW > 9) ? NW : 9;
    localparam logic [EW-1:0] MAX_N = EW'(MAX_SIZE);
    localparam logic [EW-1:0] ONE_N = EW'(1);

    logic [8:0]    grid_size_reg;
    logic          perc_mode_reg;
    logic [AW-1:0] diag_reg, diag_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [EW-1:0] gs_ext;
    logic [EW-1:0] n_eff;
    logic [EW-1:0] diag_plus1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg <= GRID_SIZE_RESET;
            perc_mode_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GRID_SIZE: grid_size_reg <= cfg_data[8:0];
                REG_PERC_MODE: perc_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        gs_ext     = EW'(grid_size_reg);
        diag_plus1 = EW'(diag_reg) + ONE_N;
        if (gs_ext == '0) begin
            n_eff = ONE_N;
        end else if (gs_ext > MAX_N) begin
            n_eff = MAX_N;
        end else begin
            n_eff = gs_ext;
        end
        flags.first_diag = (diag_reg == '0);
        flags.first_pos  = (pos_reg == '0);
        flags.eod        = (pos_reg >= diag_reg);
        flags.final_diag = (diag_plus1 >= n_eff);
        flags.is_last    = flags.eod && flags.final_diag;
        flags.perc       = perc_mode_reg;
    end

    always_comb begin
        diag_next = diag_reg;
        pos_next  = pos_reg;
        if (advance) begin
            if (flags.is_last) begin
                diag_next = '0;
                pos_next  = '0;
            end else if (flags.eod) begin
                diag_next = diag_reg + AW'(1);
                pos_next  = '0;
            end else begin
                pos_next  = pos_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diag_reg <= '0;
            pos_reg  <= '0;
        end else begin
            diag_reg <= diag_next;
            pos_reg  <= pos_next;
        end
    end

    assign pos = pos_reg;

`ifndef SYNTH
    a_pos_within_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= diag_reg)
        else $error("position ran past its diagonal");
`endif

endmodule

>>> rtl/gmp_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmp_eval
// Cell evaluation: pick the cheaper neighbor, add the cell cost, merge counts
// on a tie; fold it into the last-diagonal minimum or the zero-cost count.
// ----------------------------------------------------------------------------
module gmp_eval (
    input  gmp_pkg::cell_t    cell_cost,
    input  gmp_pkg::flags_t   flags,
    input  gmp_pkg::cost_t    up_cost,
    input  gmp_pkg::count_t   up_count,
    input  gmp_pkg::cost_t    left_cost,
    input  gmp_pkg::count_t   left_count,
    input  gmp_pkg::cost_t    rmin,
    input  gmp_pkg::count_t   rcnt,
    output gmp_pkg::cost_t    cost,
    output gmp_pkg::count_t   count,
    output gmp_pkg::cost_t    rmin_next,
    output gmp_pkg::count_t   rcnt_next
);
    import gmp_pkg::*;

    cost_t  sel_cost;
    count_t base_cnt;

    always_comb begin
        sel_cost = up_cost;
        count    = up_count;
        if (flags.first_diag) begin
            sel_cost = '0;
            count    = COUNT_ONE;
        end else if (flags.first_pos) begin
            sel_cost = up_cost;
            count    = up_count;
        end else if (flags.eod || (up_cost > left_cost)) begin
            sel_cost = left_cost;
            count    = left_count;
        end else if (up_cost < left_cost) begin
            sel_cost = up_cost;
            count    = up_count;
        end else begin
            sel_cost = up_cost;
            count    = sat_add_count(up_count, left_count);
        end
        cost = flags.first_diag ? cost_t'(cell_cost) : sat_add_cost(sel_cost, cell_cost);
    end

    always_comb begin
        rmin_next = rmin;
        rcnt_next = rcnt;
        base_cnt  = flags.first_pos ? '0 : rcnt;
        if (flags.final_diag) begin
            if (flags.perc) begin
                rmin_next = '0;
                rcnt_next = (cost == '0) ? sat_add_count(base_cnt, count) : base_cnt;
            end else if (flags.first_pos || (cost < rmin)) begin
                rmin_next = cost;
                rcnt_next = count;
            end else if (cost == rmin) begin
                rcnt_next = sat_add_count(rcnt, count);
            end
        end
    end

endmodule

>>> rtl/grid_min_path_cost_and_count_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_min_path_cost_and_count_top
// Least-cost monotone path and optimal path count over an anti-diagonal
// stream of lattice cell costs.
// ----------------------------------------------------------------------------
// Accepts one cell cost per cycle while the output side is ready and returns
// one result per cell; a cell moves from the input register to the result
// register. The sequencer knows the position of the next cell ahead of time,
// so the previous-diagonal memory is read on acceptance and its registered
// output meets the cell in the input register; a cell that needs the entry
// written in the same cycle takes it from the result register instead.
// Results wait in the result register while the next cell is already held
// in the input register. The memory is not cleared after reset: every entry
// is written on one diagonal before the next diagonal reads it. Configuration
// writes are always taken and must be made while no item is in flight.
// ----------------------------------------------------------------------------
module grid_min_path_cost_and_count_top #(
    parameter int MAX_SIZE = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [15:0]   s_tdata,    // [15:0] cell_cost
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [175:0]  m_tdata,    // [23:0] path_cost, [87:24] path_count,
                                      // [111:88] best_cost, [175:112] best_count
    output logic [0:0]    m_tuser,    // [0] end_of_diagonal
    output logic          m_tlast,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_index,
    input  logic [15:0]   cfg_data
);
    import gmp_pkg::*;

    localparam int AW = $clog2(MAX_SIZE);

    logic          accept;
    logic          move;
    logic [AW-1:0] rd_pos;
    flags_t        cur_flags;
    entry_t        mem_q;
    entry_t        wr_entry;

    logic          in_valid_reg;
    cell_t         cell_reg;
    flags_t        flags_reg;
    logic [AW-1:0] wpos_reg;
    logic          fwd_reg;

    cost_t         left_cost_reg;
    count_t        left_count_reg;
    cost_t         rmin_reg;
    count_t        rcnt_reg;

    logic          m_valid_reg;
    cost_t         cost_reg;
    count_t        count_reg;
    logic          eod_reg;
    logic          last_reg;
    cost_t         best_cost_reg;
    count_t        best_count_reg;

    cost_t         up_cost;
    count_t        up_count;
    cost_t         cost_next;
    count_t        count_next;
    cost_t         rmin_next;
    count_t        rcnt_next;

    assign move      = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || move;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    gmp_ctrl #(
        .MAX_SIZE (MAX_SIZE),
        .AW       (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .pos       (rd_pos),
        .flags     (cur_flags)
    );

    assign wr_entry.cost  = cost_next;
    assign wr_entry.count = count_next;

    gmp_store #(
        .DEPTH (MAX_SIZE),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (move),
        .wr_addr (wpos_reg),
        .wr_data (wr_entry),
        .rd_en   (accept),
        .rd_addr (rd_pos),
        .rd_data (mem_q)
    );

    assign up_cost  = fwd_reg ? cost_reg  : mem_q.cost;
    assign up_count = fwd_reg ? count_reg : mem_q.count;

    gmp_eval u_eval (
        .cell_cost  (cell_reg),
        .flags      (flags_reg),
        .up_cost    (up_cost),
        .up_count   (up_count),
        .left_cost  (left_cost_reg),
        .left_count (left_count_reg),
        .rmin       (rmin_reg),
        .rcnt       (rcnt_reg),
        .cost       (cost_next),
        .count      (count_next),
        .rmin_next  (rmin_next),
        .rcnt_next  (rcnt_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end else begin
            if (accept) begin
                in_valid_reg <= 1'b1;
                fwd_reg      <= move && (wpos_reg == rd_pos);
            end else if (move) begin
                in_valid_reg <= 1'b0;
                fwd_reg      <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cell_reg  <= s_tdata;
            flags_reg <= cur_flags;
            wpos_reg  <= rd_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_cost_reg  <= '0;
            left_count_reg <= '0;
            rmin_reg       <= '0;
            rcnt_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (move) begin
                left_cost_reg  <= up_cost;
                left_count_reg <= up_count;
                rmin_reg       <= rmin_next;
                rcnt_reg       <= rcnt_next;
                m_valid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            cost_reg       <= cost_next;
            count_reg      <= count_next;
            eod_reg        <= flags_reg.eod;
            last_reg       <= flags_reg.is_last;
            best_cost_reg  <= flags_reg.is_last ? rmin_next : '0;
            best_count_reg <= flags_reg.is_last ? rcnt_next : '0;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {best_count_reg, best_cost_reg, count_reg, cost_reg};
    assign m_tuser[0] = eod_reg;
    assign m_tlast    = last_reg;

`ifndef SYNTH
    a_fwd_only_first_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && fwd_reg) |-> flags_reg.first_pos)
        else $error("store bypass taken away from the first cell of a diagonal");

    a_best_zero_unless_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !last_reg) |-> (best_cost_reg == '0 && best_count_reg == '0))
        else $error("best cost or count set on an item that is not last");

    a_last_ends_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && last_reg) |-> eod_reg)
        else $error("last item does not close its diagonal");

    a_move_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (move && !accept) |=> !in_valid_reg)
        else $error("input register kept an item that moved on");
`endif

endmodule
